// ===== hdl/rse_pkg.sv =====
package rse_pkg;

  // fixed widths of the stream and result fields
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned FieldBits  = 16;
  localparam int unsigned CoordBitsDefault = 16;

  // configuration register indexes
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgImageHeight = 1'b1;

  // reset size of the image
  localparam logic [FieldBits-1:0] SizeReset = 16'd1;

  // byte value of a fully saturated channel
  localparam logic [ByteBits-1:0] ByteFull = 8'hff;

  // position of the next byte inside a row
  typedef enum logic [2:0] {
    PhFilter = 3'd0,
    PhRed    = 3'd1,
    PhGreen  = 3'd2,
    PhBlue   = 3'd3,
    PhAlpha  = 3'd4
  } phase_e;

  // one extracted pixel
  typedef struct packed {
    logic [FieldBits-1:0] pixel_column;
    logic [FieldBits-1:0] pixel_row;
    logic [ByteBits-1:0]  red;
    logic [ByteBits-1:0]  green;
    logic [ByteBits-1:0]  blue;
    logic                 kept;
    logic                 image_end;
  } pixel_t;

  // image size as seen by the scanner
  typedef struct packed {
    logic [FieldBits-1:0] image_width;
    logic [FieldBits-1:0] image_height;
  } size_t;

endpackage

// ===== hdl/rse_scan.sv =====
module rse_scan #(
  parameter int unsigned CoordBits = rse_pkg::CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rse_pkg::size_t               size_i,
  input  logic                         byte_take_i,
  input  logic [rse_pkg::ByteBits-1:0] data_byte_i,
  output logic                         blue_phase_o,
  output logic                         emit_o,
  output rse_pkg::pixel_t              pixel_o
);

  localparam int unsigned CmpBits =
    ((CoordBits > rse_pkg::FieldBits) ? CoordBits : rse_pkg::FieldBits) + 1;

  rse_pkg::phase_e phase_q, phase_d;
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [rse_pkg::ByteBits-1:0] red_q, red_d;
  logic [rse_pkg::ByteBits-1:0] green_q, green_d;
  logic first_q, first_d;

  logic last_col, last_row;
  logic is_null, all_full, marker;

  // end of row and end of image compares
  assign last_col = (CmpBits'(col_q) + CmpBits'(1)) >= CmpBits'(size_i.image_width);
  assign last_row = (CmpBits'(row_q) + CmpBits'(1)) >= CmpBits'(size_i.image_height);

  // pixel classification on the blue byte
  assign is_null  = (red_q == '0) && (green_q == '0) && (data_byte_i == '0);
  assign all_full = (red_q == rse_pkg::ByteFull) && (green_q == rse_pkg::ByteFull) &&
                    (data_byte_i == rse_pkg::ByteFull);
  assign marker   = first_q && all_full && (col_q == '0);

  assign blue_phase_o = (phase_q == rse_pkg::PhBlue);

  // next byte phase
  always_comb begin
    unique case (phase_q)
      rse_pkg::PhRed:   phase_d = rse_pkg::PhGreen;
      rse_pkg::PhGreen: phase_d = rse_pkg::PhBlue;
      rse_pkg::PhBlue:  phase_d = rse_pkg::PhAlpha;
      rse_pkg::PhAlpha: phase_d = last_col ? rse_pkg::PhFilter : rse_pkg::PhRed;
      default:          phase_d = rse_pkg::PhRed;
    endcase
  end

  // held bytes, counters and the result per phase
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    red_d   = red_q;
    green_d = green_q;
    first_d = first_q;
    emit_o  = 1'b0;
    unique case (phase_q)
      rse_pkg::PhRed:   red_d = data_byte_i;
      rse_pkg::PhGreen: green_d = data_byte_i;
      rse_pkg::PhBlue: begin
        emit_o = 1'b1;
        if (!is_null && !marker) begin
          first_d = 1'b0;
        end
      end
      rse_pkg::PhAlpha: begin
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            row_d   = '0;
            first_d = 1'b1;
          end else begin
            row_d = row_q + CoordBits'(1);
          end
        end else begin
          col_d = col_q + CoordBits'(1);
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    pixel_o.pixel_column = rse_pkg::FieldBits'(col_q);
    pixel_o.pixel_row    = rse_pkg::FieldBits'(row_q);
    pixel_o.red          = red_q;
    pixel_o.green        = green_q;
    pixel_o.blue         = data_byte_i;
    pixel_o.kept         = !marker;
    pixel_o.image_end    = last_col && last_row;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rse_pkg::PhFilter;
      col_q   <= '0;
      row_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
      first_q <= 1'b1;
    end else if (byte_take_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      red_q   <= red_d;
      green_q <= green_d;
      first_q <= first_d;
    end
  end

endmodule

// ===== hdl/rgba_scanline_pixel_extractor_core.sv =====
// RGBA scanline pixel extractor
//
// The input channel (in_valid_i / in_stall_o / data_byte_i) carries the
// unfiltered image stream one byte per transfer in raster order: each row is
// one filter byte followed by image_width pixels of red, green, blue, alpha.
// The output channel (out_valid_o / out_stall_i / pixel fields) carries one
// transfer per pixel, made on its blue byte, with column, row, RGB, a kept
// flag (low for a row-end marker) and image_end on the last pixel.
// Image size is set through cfg_we_i / cfg_index_i / cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.
//
// Throughput is one byte per cycle while no blue byte is held off. The pixel
// appears in the output register the cycle after its blue byte is taken. Only
// the blue byte needs room in the output register, so while a pixel waits
// under out_stall_i, filter, red, green and alpha bytes keep flowing; a blue
// byte is held off until the pixel is taken. Reset empties the output, sets
// width and height to one and waits for the filter byte of row zero.
module rgba_scanline_pixel_extractor_core #(
  parameter int unsigned COORD_BITS = rse_pkg::CoordBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rse_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [rse_pkg::FieldBits-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rse_pkg::ByteBits-1:0]   data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rse_pkg::FieldBits-1:0]  pixel_column_o,
  output logic [rse_pkg::FieldBits-1:0]  pixel_row_o,
  output logic [rse_pkg::ByteBits-1:0]   red_o,
  output logic [rse_pkg::ByteBits-1:0]   green_o,
  output logic [rse_pkg::ByteBits-1:0]   blue_o,
  output logic                           kept_o,
  output logic                           image_end_o
);

  rse_pkg::size_t  size_q;
  rse_pkg::pixel_t scan_pixel;
  rse_pkg::pixel_t pix_q;
  logic out_valid_q;
  logic blue_phase;
  logic scan_emit;
  logic in_take;
  logic out_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q.image_width  <= rse_pkg::SizeReset;
      size_q.image_height <= rse_pkg::SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rse_pkg::CfgImageWidth:  size_q.image_width  <= cfg_wdata_i;
        rse_pkg::CfgImageHeight: size_q.image_height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // only a blue byte needs a free output register
  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = out_busy && blue_phase;
  assign in_take    = in_valid_i && !in_stall_o;

  rse_scan #(
    .CoordBits(COORD_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_q),
    .byte_take_i (in_take),
    .data_byte_i (data_byte_i),
    .blue_phase_o(blue_phase),
    .emit_o      (scan_emit),
    .pixel_o     (scan_pixel)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take && scan_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && scan_emit) begin
      pix_q <= scan_pixel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_column_o = pix_q.pixel_column;
  assign pixel_row_o    = pix_q.pixel_row;
  assign red_o          = pix_q.red;
  assign green_o        = pix_q.green;
  assign blue_o         = pix_q.blue;
  assign kept_o         = pix_q.kept;
  assign image_end_o    = pix_q.image_end;

  // a waiting pixel is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_take && scan_emit && out_valid_q && out_stall_i))
    else $error("pixel overwritten while output stalled");

  // a pixel with kept low (a marker) is a saturated pixel at column zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kept_o) |-> (pixel_column_o == '0) &&
      (red_o == rse_pkg::ByteFull) && (green_o == rse_pkg::ByteFull) &&
      (blue_o == rse_pkg::ByteFull))
    else $error("row-end marker with wrong fields");

  // input is held off only by a waiting pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && blue_phase))
    else $error("input stalled without a waiting pixel");

endmodule

// ===== test/rse_checker.sv =====
// pixel predictor and scoreboard for the scanline extractor
module rse_checker
  import rse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [FieldBits-1:0]  cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [ByteBits-1:0]   data_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [FieldBits-1:0]  pixel_column_i,
  input  logic [FieldBits-1:0]  pixel_row_i,
  input  logic [ByteBits-1:0]   red_i,
  input  logic [ByteBits-1:0]   green_i,
  input  logic [ByteBits-1:0]   blue_i,
  input  logic                  kept_i,
  input  logic                  image_end_i,
  output int unsigned           fail_count_o,
  output int unsigned           pixels_due_o,
  output phase_e                stream_phase_o
);

  // predicted scanner state
  phase_e               phase;
  logic [FieldBits-1:0] width;
  logic [FieldBits-1:0] height;
  logic [FieldBits-1:0] col;
  logic [FieldBits-1:0] row;
  logic [ByteBits-1:0]  held_red;
  logic [ByteBits-1:0]  held_green;
  logic                 no_pixel_yet;

  pixel_t      due_pixels[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [FieldBits-1:0] got,
                             input logic [FieldBits-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // a size of zero acts as one
  function automatic logic at_last(input logic [FieldBits-1:0] idx,
                                   input logic [FieldBits-1:0] size);
    return ({1'b0, idx} + 17'd1) >= {1'b0, size};
  endfunction

  // advance the predicted scanner by one accepted byte
  task automatic take_byte(input logic [ByteBits-1:0] b);
    pixel_t px;
    logic   is_null;
    logic   all_full;
    logic   marker;
    case (phase)
      PhRed: begin
        held_red = b;
        phase = PhGreen;
      end
      PhGreen: begin
        held_green = b;
        phase = PhBlue;
      end
      PhBlue: begin
        is_null  = (held_red == '0) && (held_green == '0) && (b == '0);
        all_full = (held_red == ByteFull) && (held_green == ByteFull) && (b == ByteFull);
        marker   = no_pixel_yet && all_full && (col == '0);
        if (!is_null && !marker) begin
          no_pixel_yet = 1'b0;
        end
        px.pixel_column = col;
        px.pixel_row    = row;
        px.red          = held_red;
        px.green        = held_green;
        px.blue         = b;
        px.kept         = !marker;
        px.image_end    = at_last(col, width) && at_last(row, height);
        due_pixels = {due_pixels, px};
        phase = PhAlpha;
      end
      PhAlpha: begin
        if (at_last(col, width)) begin
          col = '0;
          if (at_last(row, height)) begin
            row = '0;
            no_pixel_yet = 1'b1;
          end else begin
            row = row + 16'd1;
          end
          phase = PhFilter;
        end else begin
          col = col + 16'd1;
          phase = PhRed;
        end
      end
      default: begin
        // filter byte, skipped
        phase = PhRed;
      end
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      phase          = PhFilter;
      width          = SizeReset;
      height         = SizeReset;
      col            = '0;
      row            = '0;
      held_red       = '0;
      held_green     = '0;
      no_pixel_yet   = 1'b1;
      due_pixels.delete();
      pixels_due_o   <= 0;
      stream_phase_o <= PhFilter;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgImageWidth:  width  = cfg_wdata_i;
          CfgImageHeight: height = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        take_byte(data_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel transfer (%0d,%0d) with no pixel due",
                                    pixel_column_i, pixel_row_i));
        end else begin
          want = due_pixels.pop_front();
          check_field("pixel_column", pixel_column_i, want.pixel_column);
          check_field("pixel_row", pixel_row_i, want.pixel_row);
          check_field("red", FieldBits'(red_i), FieldBits'(want.red));
          check_field("green", FieldBits'(green_i), FieldBits'(want.green));
          check_field("blue", FieldBits'(blue_i), FieldBits'(want.blue));
          check_field("kept", FieldBits'(kept_i), FieldBits'(want.kept));
          check_field("image_end", FieldBits'(image_end_i), FieldBits'(want.image_end));
        end
      end
      pixels_due_o   <= $unsigned(due_pixels.size());
      stream_phase_o <= phase;
    end
  end

endmodule

// ===== test/tb.sv =====
// stimulus and verdict for the scanline extractor
module tb;
  import rse_pkg::*;

  localparam int unsigned RandomBytes = 1250;
  localparam int unsigned CycleLimit  = 600000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = CfgImageWidth;
  logic [FieldBits-1:0]  cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ByteBits-1:0]   data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FieldBits-1:0]  pixel_column;
  logic [FieldBits-1:0]  pixel_row;
  logic [ByteBits-1:0]   red;
  logic [ByteBits-1:0]   green;
  logic [ByteBits-1:0]   blue;
  logic                  kept;
  logic                  image_end;
  int unsigned           fail_count;
  int unsigned           pixels_due;
  phase_e                stream_phase;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;

  rgba_scanline_pixel_extractor_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_column_o (pixel_column),
    .pixel_row_o    (pixel_row),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .kept_o         (kept),
    .image_end_o    (image_end)
  );

  rse_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_column_i (pixel_column),
    .pixel_row_i    (pixel_row),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .kept_i         (kept),
    .image_end_i    (image_end),
    .fail_count_o   (fail_count),
    .pixels_due_o   (pixels_due),
    .stream_phase_o (stream_phase)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [ByteBits-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_pixel(input logic [ByteBits-1:0] r, input logic [ByteBits-1:0] g,
                            input logic [ByteBits-1:0] b, input logic [ByteBits-1:0] a);
    send_byte(r);
    send_byte(g);
    send_byte(b);
    send_byte(a);
  endtask

  // hold the sender off until every pixel due has been taken
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
  endtask

  task automatic set_size(input logic [FieldBits-1:0] w, input logic [FieldBits-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CfgImageWidth;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CfgImageHeight;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // bring the stream back to the filter byte of row zero via a 1x1 image
  task automatic resync_stream();
    int pad;
    wait_drain();
    repeat (3) @(posedge clk);
    set_size(16'd1, 16'd1);
    case (stream_phase)
      PhRed:   pad = 4;
      PhGreen: pad = 3;
      PhBlue:  pad = 2;
      PhAlpha: pad = 1;
      default: pad = 5;
    endcase
    repeat (pad) send_byte(8'($urandom_range(255)));
    wait_drain();
    repeat (3) @(posedge clk);
  endtask

  function automatic longint image_bytes(input logic [FieldBits-1:0] w,
                                         input logic [FieldBits-1:0] h);
    longint we;
    longint he;
    we = (w == '0) ? 1 : w;
    he = (h == '0) ? 1 : h;
    return he * (1 + 4 * we);
  endfunction

  // raster image, cut short once the byte budget runs out
  task automatic send_image(input logic [FieldBits-1:0] w, input logic [FieldBits-1:0] h,
                            input longint budget);
    longint              bytes_left;
    int                  kind;
    int                  we;
    int                  he;
    logic [ByteBits-1:0] px[4];
    bytes_left = budget;
    we = (w == '0) ? 1 : w;
    he = (h == '0) ? 1 : h;
    for (int r = 0; r < he; r++) begin
      if (bytes_left == 0) return;
      send_byte(8'($urandom_range(255)));
      bytes_left--;
      for (int c = 0; c < we; c++) begin
        kind = $urandom_range(99);
        for (int k = 0; k < 4; k++) px[k] = 8'($urandom_range(255));
        if (kind < 15) begin
          // row-end marker candidate
          for (int k = 0; k < 3; k++) px[k] = ByteFull;
        end else if (kind < 30) begin
          // null pixel
          for (int k = 0; k < 3; k++) px[k] = '0;
        end else if (kind < 38) begin
          // almost saturated
          for (int k = 0; k < 3; k++) px[k] = ByteFull;
          px[$urandom_range(2)] = 8'($urandom_range(254));
        end
        if ($urandom_range(99) == 0) wait_drain();
        for (int k = 0; k < 4; k++) begin
          if (bytes_left == 0) return;
          send_byte(px[k]);
          bytes_left--;
        end
      end
    end
  endtask

  initial begin
    int unsigned         directed_end;
    int unsigned         phase_idx;
    int unsigned         n_images;
    int unsigned         pick;
    logic [FieldBits-1:0] w;
    logic [FieldBits-1:0] h;
    longint              full_len;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // marker and null pixel at reset size
    send_byte(8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h00);
    send_byte(8'h04);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hff);

    // 2x2: null at column zero, saturated later in the row and on the next row
    wait_drain();
    repeat (3) @(posedge clk);
    set_size(16'd2, 16'd2);
    send_byte(8'h01);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h80);
    send_byte(8'h02);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h01);
    send_pixel(8'h01, 8'h02, 8'h03, 8'h04);

    // largest and zero sizes
    resync_stream();
    set_size(16'hffff, 16'hffff);
    send_image(16'hffff, 16'hffff, 41);
    resync_stream();
    set_size(16'h0000, 16'h0000);
    send_image(16'h0000, 16'h0000, image_bytes(16'h0000, 16'h0000));
    send_image(16'h0000, 16'h0000, image_bytes(16'h0000, 16'h0000));
    directed_end = bytes_sent;

    // random images under rotating idle patterns
    phase_idx = 0;
    while (bytes_sent < directed_end + RandomBytes) begin
      resync_stream();
      case (phase_idx % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      pick = $urandom_range(99);
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 3));
      if (pick < 5) begin
        w = 16'hffff;
      end else if (pick < 9) begin
        w = 16'($urandom_range(1, 2));
        h = 16'hffff;
      end else if (pick < 14) begin
        w = '0;
      end else if (pick < 19) begin
        h = '0;
      end
      set_size(w, h);
      full_len = image_bytes(w, h);
      n_images = $urandom_range(1, 4);
      for (int i = 0; i < n_images; i++) begin
        pick = $urandom_range(99);
        if (full_len > 200) begin
          send_image(w, h, $urandom_range(1, 60));
          break;
        end else if (pick < 8) begin
          // broken image
          send_image(w, h, $urandom_range(1, int'(full_len)));
          break;
        end else if (pick < 13) begin
          // noise
          repeat ($urandom_range(1, 9)) send_byte(8'($urandom_range(255)));
          break;
        end else begin
          send_image(w, h, full_len);
        end
      end
      phase_idx++;
    end

    // drain and verdict
    stall_pct = 0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pixels_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rse_pkg.sv
hdl/rse_scan.sv
hdl/rgba_scanline_pixel_extractor_core.sv
test/rse_checker.sv
test/tb.sv
